[rtl/wildcard_byte_pattern_scan_top_macros.svh]
// Assertion macros for the wildcard byte pattern scan block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define WBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

[rtl/wbps_pkg.sv]
// Package for the wildcard byte pattern scan: payload types, register codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int CFG_BYTES   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 5;
    localparam int PAT_IDX_W   = 4;

    localparam logic [7:0] LO_NIBBLE = 8'h0F;
    localparam logic [7:0] HI_NIBBLE = 8'hF0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 8'd0,
        REG_PATTERN_HIGH = 8'd1,
        REG_CARE_MASK    = 8'd2,
        REG_PATTERN_LEN  = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              region_start;
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              region_end;
    } t_scan_in;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_scan_out;

endpackage

[rtl/wbps_if.sv]
// Channel interfaces of the wildcard byte pattern scan: byte input, result output and
// configuration write. Depends on wbps_pkg.
`timescale 1ns / 1ps

interface wbps_scan_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              region_start;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_end;

    modport source (output valid, region_start, data_byte, byte_address, region_end,
                    input ready);
    modport sink (input valid, region_start, data_byte, byte_address, region_end,
                  output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink (input valid, found, match_address, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [63:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/wildcard_byte_pattern_scan_top.sv]
// Wildcard byte pattern scan: one byte per beat, at most one result per region.
// A byte beat is held in input register r_s1; its result is registered in r_out.
// Throughput: one byte per cycle, by window shift and parallel compare, unless output stalls.
// Reset (i_rst_n, synchronous): clears handshake state, window fill and done mark, and
// returns the configuration registers to their reset values; no clearing pass is needed.
// Depends on wbps_pkg, wbps_if.sv and wildcard_byte_pattern_scan_top_macros.svh.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_top_macros.svh"

module wildcard_byte_pattern_scan_top import wbps_pkg::*; #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wbps_scan_if.sink            i_scan,
    wbps_cfg_if.sink             i_cfg,
    wbps_result_if.source        o_result
);

    localparam int WIN_BYTES = (PATTERN_BYTES < CFG_BYTES) ? PATTERN_BYTES : CFG_BYTES;
    localparam int FILL_W    = $clog2(WIN_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_BYTES);
    localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(WIN_BYTES);

    // Configuration registers.
    logic [63:0]      r_pat_low;
    logic [63:0]      r_pat_high;
    logic [31:0]      r_care_mask;
    logic [LEN_W-1:0] r_pat_len;

    // Input register and region state.
    logic        r_s1_valid;
    t_scan_in    r_s1;
    logic [7:0]  r_window [WIN_BYTES];
    logic [7:0]  n_window [WIN_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic        r_done;
    logic        n_done;

    // Result register.
    logic        r_out_valid;
    t_scan_out   r_out;

    logic [7:0]  w_pat  [CFG_BYTES];
    logic [7:0]  w_care [CFG_BYTES];
    logic [7:0]  w_shift [WIN_BYTES];
    logic [FILL_W-1:0] w_base_fill;
    logic [FILL_W-1:0] w_new_fill;
    logic        w_base_done;
    logic [WIN_BYTES-1:0] w_pos_ok;
    logic        w_match;
    logic        w_emit;
    logic        w_adv;
    logic [ADDR_W-1:0] w_addr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_care_mask <= '1;
            r_pat_len   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PATTERN_LOW:  r_pat_low   <= i_cfg.data;
                REG_PATTERN_HIGH: r_pat_high  <= i_cfg.data;
                REG_CARE_MASK:    r_care_mask <= i_cfg.data[31:0];
                REG_PATTERN_LEN:  r_pat_len   <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < CFG_BYTES; k++) begin
            w_pat[k]  = (k < 8) ? r_pat_low[8*(k%8) +: 8] : r_pat_high[8*(k%8) +: 8];
            w_care[k] = (r_care_mask[2*k] ? LO_NIBBLE : 8'h00)
                      | (r_care_mask[2*k+1] ? HI_NIBBLE : 8'h00);
        end
    end

    assign w_adv        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_scan.ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_s1_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_s1.region_start <= i_scan.region_start;
            r_s1.data_byte    <= i_scan.data_byte;
            r_s1.byte_address <= i_scan.byte_address;
            r_s1.region_end   <= i_scan.region_end;
        end
    end

    assign w_base_fill = r_s1.region_start ? '0 : r_fill;
    assign w_base_done = r_s1.region_start ? 1'b0 : r_done;
    assign w_new_fill  = (w_base_fill == FILL_MAX) ? FILL_MAX : w_base_fill + 1'b1;

    always_comb begin
        logic [PAT_IDX_W-1:0] p;
        logic [7:0]           d;
        w_shift[0] = r_s1.data_byte;
        for (int j = 1; j < WIN_BYTES; j++) begin
            w_shift[j] = r_window[j-1];
        end
        for (int j = 0; j < WIN_BYTES; j++) begin
            p = PAT_IDX_W'(r_pat_len - LEN_W'(1) - LEN_W'(j));
            d = w_shift[j];
            w_pos_ok[j] = (LEN_W'(j) >= r_pat_len) || (((d ^ w_pat[p]) & w_care[p]) == 8'h00);
        end
    end

    assign w_match = (r_pat_len != '0) && (r_pat_len <= LEN_CAP)
                  && (LEN_W'(w_new_fill) >= r_pat_len) && (&w_pos_ok);
    assign w_emit  = !w_base_done && (w_match || r_s1.region_end);
    assign w_addr  = r_s1.byte_address + ADDR_W'(1) - ADDR_W'(r_pat_len);

    always_comb begin
        for (int j = 0; j < WIN_BYTES; j++) begin
            n_window[j] = w_base_done ? r_window[j] : w_shift[j];
        end
        if (r_s1.region_end) begin
            n_fill = '0;
            n_done = 1'b0;
        end else if (w_base_done) begin
            n_fill = w_base_fill;
            n_done = 1'b1;
        end else begin
            n_fill = w_new_fill;
            n_done = w_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else if (w_adv) begin
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < WIN_BYTES; j++) begin
                r_window[j] <= n_window[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out.found         <= w_match;
            r_out.match_address <= w_match ? w_addr : '0;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.found         = r_out.found;
    assign o_result.match_address = r_out.match_address;

    `WBPS_ASSERT_NOW(a_miss_only_at_end, i_clk, i_rst_n, w_adv && w_emit && !w_match, r_s1.region_end)
    `WBPS_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, w_adv && r_s1.region_end, (r_fill == '0) && !r_done)
    `WBPS_ASSERT_NOW(a_out_rise_from_adv, i_clk, i_rst_n, $rose(r_out_valid), $past(w_adv && w_emit))
    `WBPS_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, r_s1_valid, r_fill <= FILL_MAX)
    `WBPS_ASSERT_NEXT(a_hit_sets_done, i_clk, i_rst_n, w_adv && w_emit && w_match && !r_s1.region_end, r_done)

endmodule

[tb/sv/tb_wildcard_byte_pattern_scan_top.sv]
// Self-checking testbench for wildcard_byte_pattern_scan_top: drives byte beats and register
// writes, predicts each region's result and checks every result beat in order.
// Depends on wbps_pkg, the channel interfaces in wbps_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scan_top;
    import wbps_pkg::*;

    localparam int SCAN_BYTES   = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_PRINTED  = 40;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd9;

    logic i_clk;
    logic i_rst_n;

    wbps_scan_if   scan_if ();
    wbps_cfg_if    cfg_if ();
    wbps_result_if result_if ();

    wildcard_byte_pattern_scan_top #(.PATTERN_BYTES(SCAN_BYTES)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (scan_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    class match_scoreboard;
        logic [63:0]      pat_lo;
        logic [63:0]      pat_hi;
        logic [31:0]      care_mask;
        logic [LEN_W-1:0] pat_len;
        logic [7:0]       window [SCAN_BYTES];
        int unsigned      fill;
        bit               done;
        t_scan_out        pending_matches [$];
        int unsigned      errors;

        function new();
            pat_lo    = '0;
            pat_hi    = '0;
            care_mask = '1;
            pat_len   = '0;
            errors    = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (window[k]) window[k] = 8'h00;
            fill = 0;
            done = 1'b0;
        endfunction

        function logic [7:0] pat_byte(int unsigned k);
            logic [127:0] both;
            both = {pat_hi, pat_lo};
            return both[8*k +: 8];
        endfunction

        function logic [7:0] care_of(int unsigned k);
            logic [1:0] m;
            m = care_mask[2*k +: 2];
            return (m[0] ? LO_NIBBLE : 8'h00) | (m[1] ? HI_NIBBLE : 8'h00);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_LOW:  pat_lo    = value;
                REG_PATTERN_HIGH: pat_hi    = value;
                REG_CARE_MASK:    care_mask = value[31:0];
                REG_PATTERN_LEN:  pat_len   = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit window_hit();
            int unsigned cap;
            cap = (SCAN_BYTES < CFG_BYTES) ? SCAN_BYTES : CFG_BYTES;
            if (pat_len == 0 || pat_len > cap || fill < pat_len) return 1'b0;
            for (int unsigned k = 0; k < pat_len; k++) begin
                if (((window[pat_len - 1 - k] ^ pat_byte(k)) & care_of(k)) != 8'h00)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(t_scan_in b);
            t_scan_out m;
            if (b.region_start) clear_window();
            if (!done) begin
                for (int k = SCAN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = b.data_byte;
                if (fill < SCAN_BYTES) fill++;
                if (window_hit()) begin
                    m.found         = 1'b1;
                    m.match_address = b.byte_address - (64'(pat_len) - 64'd1);
                    pending_matches = {pending_matches, m};
                    done = 1'b1;
                end else if (b.region_end) begin
                    m.found         = 1'b0;
                    m.match_address = '0;
                    pending_matches = {pending_matches, m};
                end
            end
            if (b.region_end) clear_window();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_match(t_scan_out got);
            t_scan_out want;
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("result with none expected: found %0b address %h",
                                          got.found, got.match_address));
                return;
            end
            want = pending_matches.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.match_address !== want.match_address)
                report_mismatch($sformatf("match_address %h, expected %h",
                                          got.match_address, want.match_address));
        endtask
    endclass

    match_scoreboard sb = new();

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 67;
    int unsigned items_sent    = 0;
    int unsigned stall_cycles  = 0;
    bit          hold_ready    = 1'b0;
    bit          pressure_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_scan_in mk_byte(bit opens, logic [7:0] data, logic [63:0] addr,
                                         bit closes);
        t_scan_in b;
        b.region_start = opens;
        b.data_byte    = data;
        b.byte_address = addr;
        b.region_end   = closes;
        return b;
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] fitted_byte(int unsigned k);
        logic [7:0] care;
        care = sb.care_of(k);
        return (sb.pat_byte(k) & care) | (8'($urandom) & ~care);
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(1) == 0) return 8'($urandom);
        return fitted_byte($urandom_range(CFG_BYTES - 1));
    endfunction

    task automatic send_byte(input t_scan_in b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            scan_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        scan_if.valid        <= 1'b1;
        scan_if.region_start <= b.region_start;
        scan_if.data_byte    <= b.data_byte;
        scan_if.byte_address <= b.byte_address;
        scan_if.region_end   <= b.region_end;
        do @(posedge i_clk); while (scan_if.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // A byte that leaves no result may still be in flight, hence the extra cycles.
    task automatic wait_quiet();
        @(negedge i_clk);
        scan_if.valid <= 1'b0;
        while (sb.pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [63:0] top;
        top = '1;
        send_byte(mk_byte(1'b1, 8'h00, 64'h0, 1'b1));
        send_byte(mk_byte(1'b1, 8'hFF, top, 1'b1));
        wait_quiet();
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_00FF_00A5);
        write_reg(REG_PATTERN_LEN, 64'd3);
        write_reg(REG_SPARE, 64'd1);
        send_byte(mk_byte(1'b1, 8'h12, top - 64'd1, 1'b0));
        send_byte(mk_byte(1'b0, 8'hA5, top, 1'b0));
        send_byte(mk_byte(1'b0, 8'h00, 64'h0, 1'b0));
        send_byte(mk_byte(1'b0, 8'hFF, 64'h1, 1'b0));
        send_byte(mk_byte(1'b0, 8'h55, 64'h2, 1'b0));
        send_byte(mk_byte(1'b0, 8'h66, 64'h3, 1'b1));
        send_byte(mk_byte(1'b1, 8'hA5, 64'h10, 1'b0));
        send_byte(mk_byte(1'b0, 8'h00, 64'h11, 1'b0));
        send_byte(mk_byte(1'b0, 8'hFF, 64'h12, 1'b1));
        send_byte(mk_byte(1'b0, 8'hA5, 64'h20, 1'b0));
        send_byte(mk_byte(1'b0, 8'h00, 64'h21, 1'b0));
        send_byte(mk_byte(1'b0, 8'hFF, 64'h22, 1'b1));
        send_byte(mk_byte(1'b1, 8'hA5, 64'h30, 1'b1));
        wait_quiet();
        write_reg(REG_CARE_MASK, 64'hFFFF_FFFF_0000_0000);
        write_reg(REG_PATTERN_LEN, 64'd17);
        send_byte(mk_byte(1'b1, 8'h5A, 64'h40, 1'b1));
        wait_quiet();
        write_reg(REG_PATTERN_LOW, 64'h5A3C);
        write_reg(REG_CARE_MASK, 64'hFFFF_FFFE);
        write_reg(REG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE2);
        send_byte(mk_byte(1'b1, 8'h3F, 64'h50, 1'b0));
        send_byte(mk_byte(1'b0, 8'h5A, 64'h51, 1'b1));
        send_byte(mk_byte(1'b1, 8'h30, 64'h60, 1'b0));
        send_byte(mk_byte(1'b1, 8'h31, 64'h61, 1'b0));
        send_byte(mk_byte(1'b0, 8'h5A, 64'h62, 1'b1));
    endtask

    task automatic apply_random_setting();
        logic [63:0] value;
        int unsigned pick;
        wait_quiet();
        write_reg(REG_PATTERN_LOW, random_word());
        write_reg(REG_PATTERN_HIGH, random_word());
        pick  = $urandom_range(99);
        value = {$urandom, $urandom};
        if (pick < 40) value[31:0] = '1;
        else if (pick < 52) value[31:0] = '0;
        else if (pick < 70) value[31:0] = ~($urandom & $urandom & $urandom);
        write_reg(REG_CARE_MASK, value);
        pick  = $urandom_range(99);
        value = {$urandom, $urandom};
        if (pick < 6) value[LEN_W-1:0] = '0;
        else if (pick < 12) value[LEN_W-1:0] = 5'd16;
        else if (pick < 17) value[LEN_W-1:0] = LEN_W'($urandom_range(31, 17));
        else if (pick < 55) value[LEN_W-1:0] = LEN_W'($urandom_range(3, 1));
        else value[LEN_W-1:0] = LEN_W'($urandom_range(15, 4));
        write_reg(REG_PATTERN_LEN, value);
        if ($urandom_range(9) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    endtask

    // Mostly well-formed regions holding the pattern, some with a damaged copy,
    // a missing opening or a missing closing beat.
    task automatic send_region();
        logic [7:0]  body [$];
        logic [63:0] addr;
        int unsigned span;
        int unsigned plen;
        int unsigned at;
        bit          opens;
        bit          closes;
        plen = sb.pat_len;
        span = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
        if (plen >= 1 && plen <= CFG_BYTES && span < plen && $urandom_range(1) == 0)
            span = plen + $urandom_range(8);
        for (int k = 0; k < span; k++) body = {body, noise_byte()};
        if (plen >= 1 && plen <= CFG_BYTES && plen <= span && $urandom_range(99) < 70) begin
            at = ($urandom_range(3) == 0) ? span - plen : $urandom_range(span - plen);
            for (int k = 0; k < plen; k++) body[at + k] = fitted_byte(k);
            if ($urandom_range(4) == 0) begin
                at = at + $urandom_range(plen - 1);
                body[at] = body[at] ^ (8'h01 << $urandom_range(7));
            end
        end
        case ($urandom_range(9))
            0: addr = '0;
            1: addr = ~64'($urandom_range(20));
            default: addr = {$urandom, $urandom};
        endcase
        opens  = ($urandom_range(19) != 0);
        closes = ($urandom_range(19) != 0);
        for (int k = 0; k < span; k++) begin
            if ($urandom_range(49) == 0) addr = {$urandom, $urandom};
            send_byte(mk_byte(opens && k == 0, body[k], addr, closes && k == span - 1));
            addr = addr + 64'd1;
        end
    endtask

    task automatic run_batch(input int unsigned n);
        int unsigned stop_at;
        apply_random_setting();
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(19) == 0) begin
                repeat ($urandom_range(4, 1))
                    send_byte(mk_byte(1'($urandom_range(1)), 8'($urandom),
                                      {$urandom, $urandom}, 1'($urandom_range(1))));
            end else begin
                send_region();
            end
        end
    endtask

    // Every one-byte region hits, so the block stalls the byte input while the receiver holds off.
    task automatic fill_while_held();
        wait_quiet();
        write_reg(REG_CARE_MASK, 64'h0);
        write_reg(REG_PATTERN_LEN, 64'd1);
        hold_ready = 1'b1;
        repeat (40) send_byte(mk_byte(1'b1, 8'($urandom), {$urandom, $urandom}, 1'b1));
    endtask

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ready) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_ready = 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_scan_in  b;
        t_scan_out r;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (scan_if.valid && scan_if.ready) begin
                b.region_start = scan_if.region_start;
                b.data_byte    = scan_if.data_byte;
                b.byte_address = scan_if.byte_address;
                b.region_end   = scan_if.region_end;
                sb.take_byte(b);
                moved = 1'b1;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.write_reg(cfg_if.index, cfg_if.data);
                moved = 1'b1;
            end
            if (result_if.valid && result_if.ready) begin
                r.found         = result_if.found;
                r.match_address = result_if.match_address;
                sb.check_match(r);
                moved = 1'b1;
            end
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("** wildcard_byte_pattern_scan_top: FAILED **");
        $finish;
    end

    initial begin
        scan_if.valid        = 1'b0;
        scan_if.region_start = 1'b0;
        scan_if.data_byte    = '0;
        scan_if.byte_address = '0;
        scan_if.region_end   = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        i_rst_n              = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 67;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!pressure_done) begin
                    fill_while_held();
                    pressure_done = 1'b1;
                end
            end
            run_batch($urandom_range(80, 30));
        end
        wait_quiet();
        if (sb.pending_matches.size() != 0)
            sb.report_mismatch("results still expected at the end of the run");
        if (sb.errors == 0) begin
            $display("** wildcard_byte_pattern_scan_top: PASSED **");
        end else begin
            $display("** wildcard_byte_pattern_scan_top: FAILED **");
        end
        $finish;
    end

endmodule
